// File: design/affine3d_inlier_scoring_macros.svh
// Assertion macros for the affine 3-D inlier scoring block.
// Depends on nothing; the macros expect aclk and aresetn in the scope of use.
`ifndef AFFINE3D_INLIER_SCORING_MACROS_SVH
`define AFFINE3D_INLIER_SCORING_MACROS_SVH

// Same-cycle implication, checked outside reset
`define AF3D_ASSERT_IMPLIES(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define AF3D_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: design/af3d_pkg.sv
// Package for the affine 3-D inlier scoring block: widths, codes, sequencer types
// and the per-step schedule of the shared multiplier. Depends on nothing.
package af3d_pkg;

    localparam int MAX_POINTS    = 65536;
    localparam int CNT_W         = 17;
    localparam int COUNT_MAX     = (1 << CNT_W) - 1;
    localparam int COUNT_CAP_INT = (MAX_POINTS < COUNT_MAX) ? MAX_POINTS : COUNT_MAX;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(COUNT_CAP_INT);

    localparam int COEF_COUNT = 12;
    localparam int COEF_IDX_W = 4;
    localparam int Q_W        = 32;
    localparam int FRAC_W     = 16;
    localparam int RES_W      = 64;
    localparam int OPND_W     = Q_W + 1;
    localparam int PROD_W     = 2 * OPND_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int COMP_W     = ACC_W - FRAC_W;
    localparam int MAG_W      = COMP_W + 1;
    localparam int IN_DATA_W  = 232;
    localparam int OUT_DATA_W = 88;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    localparam logic [Q_W-1:0] DIST_RESET = 32'd196608;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LIM,
        MUL_PROD,
        MUL_SQ
    } mul_op_t;

    typedef struct packed {
        logic [COEF_IDX_W-1:0] rd_addr;
        logic                  base_en;
        logic [1:0]            base_row;
        mul_op_t               mul_op;
        logic [1:0]            mul_row;
        logic [1:0]            mul_k;
    } step_ctl_t;

    // Schedule: coefficient read the step before use; row base (offset minus target)
    // in non-MUL_PROD steps; squares in the first free multiplier slot after each row.
    function automatic step_ctl_t step_decode(input logic [STEP_W-1:0] step);
        step_ctl_t c;
        c = '0;
        unique case (step)
            4'd0: begin
                c.rd_addr = 4'd3;
                c.mul_op  = MUL_LIM;
            end
            4'd1: begin
                c.rd_addr  = 4'd0;
                c.base_en  = 1'b1;
                c.base_row = 2'd0;
            end
            4'd2: begin
                c.rd_addr = 4'd1;
                c.mul_op  = MUL_PROD;
                c.mul_row = 2'd0;
                c.mul_k   = 2'd0;
            end
            4'd3: begin
                c.rd_addr = 4'd2;
                c.mul_op  = MUL_PROD;
                c.mul_row = 2'd0;
                c.mul_k   = 2'd1;
            end
            4'd4: begin
                c.rd_addr = 4'd7;
                c.mul_op  = MUL_PROD;
                c.mul_row = 2'd0;
                c.mul_k   = 2'd2;
            end
            4'd5: begin
                c.rd_addr  = 4'd4;
                c.base_en  = 1'b1;
                c.base_row = 2'd1;
            end
            4'd6: begin
                c.rd_addr = 4'd5;
                c.mul_op  = MUL_PROD;
                c.mul_row = 2'd1;
                c.mul_k   = 2'd0;
            end
            4'd7: begin
                c.rd_addr = 4'd6;
                c.mul_op  = MUL_PROD;
                c.mul_row = 2'd1;
                c.mul_k   = 2'd1;
            end
            4'd8: begin
                c.rd_addr = 4'd11;
                c.mul_op  = MUL_PROD;
                c.mul_row = 2'd1;
                c.mul_k   = 2'd2;
            end
            4'd9: begin
                c.rd_addr  = 4'd8;
                c.base_en  = 1'b1;
                c.base_row = 2'd2;
                c.mul_op   = MUL_SQ;
                c.mul_row  = 2'd0;
            end
            4'd10: begin
                c.rd_addr = 4'd9;
                c.mul_op  = MUL_PROD;
                c.mul_row = 2'd2;
                c.mul_k   = 2'd0;
            end
            4'd11: begin
                c.rd_addr = 4'd10;
                c.mul_op  = MUL_PROD;
                c.mul_row = 2'd2;
                c.mul_k   = 2'd1;
            end
            4'd12: begin
                c.mul_op  = MUL_PROD;
                c.mul_row = 2'd2;
                c.mul_k   = 2'd2;
            end
            4'd13: begin
                c.mul_op  = MUL_SQ;
                c.mul_row = 2'd1;
            end
            4'd14: begin
                c.mul_op  = MUL_SQ;
                c.mul_row = 2'd2;
            end
            default: begin
            end
        endcase
        return c;
    endfunction

endpackage

// File: design/affine3d_inlier_scoring.sv
// Affine 3-D inlier scoring: applies a 3x4 Q16.16 affine model to point pairs and
// reports the saturated squared residual, an inlier flag and a running count per set.
// Depends on af3d_pkg and affine3d_inlier_scoring_macros.svh.
//
// A load item (tuser = 0) writes one model coefficient and leaves the block ready
// for the next item; a coefficient index past eleven is dropped and gives no result.
// A point item (tuser = 1) gives one result and occupies the block from accept to the
// next possible accept: the accept, 16 sequencer steps and a finish step that stalls
// on a full output. This is set by the single 33x33 multiplier, which serves thirteen
// multiplications per point (nine model products, three component squares and the
// squared distance limit), and by the one-port coefficient memory that feeds it one
// entry a cycle. Each residual component is formed exactly, floored to Q16.16 and
// squared; a component of magnitude 2^32 or more, or an overflowing sum, gives a
// residual of all ones, which never counts as an inlier. The inlier count saturates
// at 65536, is reported with the item marked tlast and then cleared. The result
// waits in an output register, so the next item is taken while it is not yet drained.
// Coefficients must be loaded before scoring; they have no reset value.
`include "affine3d_inlier_scoring_macros.svh"

module affine3d_inlier_scoring (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: inlier distance limit, unsigned Q16.16
    input  logic                              cfg_we,
    input  logic [af3d_pkg::Q_W-1:0]          cfg_wdata,
    // input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // coef_index[3:0], coef_value[35:4], src_x[67:36], src_y[99:68],
    // src_z[131:100], dst_x[163:132], dst_y[195:164], dst_z[227:196], zeros above
    input  logic [af3d_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,   // op
    input  logic                              s_tlast,   // last_point
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // residual_sq[63:0], inlier_total[80:64], zeros above
    output logic [af3d_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,   // is_inlier
    output logic                              m_tlast    // set_done
);
    import af3d_pkg::*;

    // Control registers
    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    mul_op_t             mul_op_d_reg, mul_op_d_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [Q_W-1:0]      dist_reg, dist_next;

    // Datapath registers
    logic [Q_W-1:0]           coef_mem [0:COEF_COUNT-1];
    logic [Q_W-1:0]           coef_rd_reg;
    logic [Q_W-1:0]           src_x_reg, src_y_reg, src_z_reg;
    logic [Q_W-1:0]           dst_x_reg, dst_y_reg, dst_z_reg;
    logic                     last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [1:0]               mul_row_d_reg;
    logic [1:0]               mul_k_d_reg;
    logic [ACC_W-1:0]         base_reg, acc_reg;
    logic [Q_W-1:0]           mag_reg [0:2];
    logic                     big_reg [0:2];
    logic [RES_W-1:0]         res_reg, res_next;
    logic [RES_W-1:0]         lim_reg;
    logic [RES_W-1:0]         out_res_reg;
    logic [CNT_W-1:0]         out_total_reg;
    logic                     out_inlier_reg;
    logic                     out_last_reg;

    // Combinational
    step_ctl_t                ctl;
    logic                     run;
    logic                     accept;
    logic                     out_load;
    logic [COEF_IDX_W-1:0]    in_coef_index;
    logic [Q_W-1:0]           in_coef_value;
    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic [Q_W-1:0]           src_sel, dst_sel, sq_opnd;
    logic signed [OPND_W-1:0] base_diff;
    logic [ACC_W-1:0]         base_next;
    logic [ACC_W-1:0]         prod_ext;
    logic [ACC_W-1:0]         acc_next;
    logic [COMP_W-1:0]        comp_floor;
    logic [MAG_W-1:0]         comp_sext, comp_mag;
    logic                     comp_big;
    logic [RES_W:0]           sq_sum;
    logic                     sq_big;
    logic                     is_inlier;
    logic [CNT_W-1:0]         count_inc;

    assign in_coef_index = s_tdata[3:0];
    assign in_coef_value = s_tdata[35:4];

    assign run      = (state_reg == ST_RUN);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign ctl      = step_decode(step_reg);

    // ---------------------------------------------------------------
    // Sequencer and result handshake
    // ---------------------------------------------------------------
    assign is_inlier = (res_reg <= lim_reg);
    assign count_inc = (is_inlier && (count_reg < COUNT_CAP)) ? count_reg + 1'b1 : count_reg;

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        dist_next     = cfg_we ? cfg_wdata : dist_reg;
        mul_op_d_next = run ? ctl.mul_op : MUL_NONE;
        m_tvalid_next = (m_tvalid_reg && !m_tready) || out_load;
        unique case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                // load items finish here; a point item starts the sequencer
                if (accept && (s_tuser == OP_SCORE)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (out_load) begin
                    state_next = ST_IDLE;
                    count_next = last_reg ? '0 : count_inc;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            mul_op_d_reg <= MUL_NONE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            dist_reg     <= DIST_RESET;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            mul_op_d_reg <= mul_op_d_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            dist_reg     <= dist_next;
        end
    end

    // ---------------------------------------------------------------
    // Coefficient memory: one write port (load items), one registered read
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == OP_LOAD) && (in_coef_index < COEF_IDX_W'(COEF_COUNT))) begin
            coef_mem[in_coef_index] <= in_coef_value;
        end
        coef_rd_reg <= coef_mem[ctl.rd_addr];
    end

    // ---------------------------------------------------------------
    // Shared multiplier: operand select, product register
    // ---------------------------------------------------------------
    always_comb begin
        case (ctl.mul_k)
            2'd0:    src_sel = src_x_reg;
            2'd1:    src_sel = src_y_reg;
            default: src_sel = src_z_reg;
        endcase
        case (ctl.mul_row)
            2'd0:    sq_opnd = mag_reg[0];
            2'd1:    sq_opnd = mag_reg[1];
            default: sq_opnd = mag_reg[2];
        endcase
        case (ctl.base_row)
            2'd0:    dst_sel = dst_x_reg;
            2'd1:    dst_sel = dst_y_reg;
            default: dst_sel = dst_z_reg;
        endcase
    end

    always_comb begin
        unique case (ctl.mul_op)
            MUL_LIM: begin
                mul_a = $signed({1'b0, dist_reg});
                mul_b = $signed({1'b0, dist_reg});
            end
            MUL_PROD: begin
                mul_a = $signed({coef_rd_reg[Q_W-1], coef_rd_reg});
                mul_b = $signed({src_sel[Q_W-1], src_sel});
            end
            MUL_SQ: begin
                mul_a = $signed({1'b0, sq_opnd});
                mul_b = $signed({1'b0, sq_opnd});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Row base: (offset coefficient - target) scaled to Q32.32
    assign base_diff = $signed({coef_rd_reg[Q_W-1], coef_rd_reg}) -
                       $signed({dst_sel[Q_W-1], dst_sel});
    assign base_next = {{(ACC_W - OPND_W - FRAC_W){base_diff[OPND_W-1]}},
                        base_diff, {FRAC_W{1'b0}}};

    // ---------------------------------------------------------------
    // Accumulate stage: row sums, floor to Q16.16, magnitude and range check
    // ---------------------------------------------------------------
    assign prod_ext   = {prod_reg[PROD_W-1], prod_reg};
    assign acc_next   = ((mul_k_d_reg == 2'd0) ? base_reg : acc_reg) + prod_ext;
    assign comp_floor = acc_next[ACC_W-1:FRAC_W];
    assign comp_sext  = {comp_floor[COMP_W-1], comp_floor};
    assign comp_mag   = comp_floor[COMP_W-1] ? (MAG_W'(0) - comp_sext) : comp_sext;
    assign comp_big   = |comp_mag[MAG_W-1:Q_W];

    always_comb begin
        case (mul_row_d_reg)
            2'd0:    sq_big = big_reg[0];
            2'd1:    sq_big = big_reg[1];
            default: sq_big = big_reg[2];
        endcase
    end

    // Saturating sum of squares
    assign sq_sum   = {1'b0, res_reg} + {1'b0, prod_reg[RES_W-1:0]};
    assign res_next = (sq_big || sq_sum[RES_W]) ? {RES_W{1'b1}} : sq_sum[RES_W-1:0];

    always_ff @(posedge aclk) begin
        // capture the point on accept; clear the sum for the new item
        if (accept && (s_tuser == OP_SCORE)) begin
            src_x_reg <= s_tdata[67:36];
            src_y_reg <= s_tdata[99:68];
            src_z_reg <= s_tdata[131:100];
            dst_x_reg <= s_tdata[163:132];
            dst_y_reg <= s_tdata[195:164];
            dst_z_reg <= s_tdata[227:196];
            last_reg  <= s_tlast;
        end

        prod_reg      <= prod_next;
        mul_row_d_reg <= ctl.mul_row;
        mul_k_d_reg   <= ctl.mul_k;

        if (run && ctl.base_en) begin
            base_reg <= base_next;
        end

        if (accept) begin
            res_reg <= '0;
        end else begin
            unique case (mul_op_d_reg)
                MUL_LIM: begin
                    lim_reg <= prod_reg[RES_W-1:0];
                end
                MUL_PROD: begin
                    acc_reg <= acc_next;
                    // third product closes the row
                    if (mul_k_d_reg == 2'd2) begin
                        case (mul_row_d_reg)
                            2'd0: begin
                                mag_reg[0] <= comp_mag[Q_W-1:0];
                                big_reg[0] <= comp_big;
                            end
                            2'd1: begin
                                mag_reg[1] <= comp_mag[Q_W-1:0];
                                big_reg[1] <= comp_big;
                            end
                            default: begin
                                mag_reg[2] <= comp_mag[Q_W-1:0];
                                big_reg[2] <= comp_big;
                            end
                        endcase
                    end
                end
                MUL_SQ: begin
                    res_reg <= res_next;
                end
                default: begin
                end
            endcase
        end

        // output register: load the finished result
        if (out_load) begin
            out_res_reg    <= res_reg;
            out_inlier_reg <= is_inlier;
            out_total_reg  <= count_inc;
            out_last_reg   <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - RES_W - CNT_W){1'b0}}, out_total_reg, out_res_reg};
    assign m_tuser  = out_inlier_reg;
    assign m_tlast  = out_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `AF3D_ASSERT_IMPLIES(a_count_cap, 1'b1, count_reg <= COUNT_CAP, "inlier count past its cap")
    `AF3D_ASSERT_NEXT(a_score_starts, accept && (s_tuser == OP_SCORE), state_reg == ST_RUN, "point item did not start the sequencer")
    `AF3D_ASSERT_IMPLIES(a_result_origin, $rose(m_tvalid_reg), $past(state_reg) == ST_FINISH, "result appeared outside the finish step")
    `AF3D_ASSERT_IMPLIES(a_sat_not_inlier, m_tvalid_reg && out_inlier_reg, out_res_reg != {RES_W{1'b1}}, "saturated residual flagged as inlier")

endmodule

// File: tb/sv/affine3d_inlier_scoring_checker.sv
// Checker for the affine 3-D inlier scoring block: watches both streams, predicts each
// point result from its own model state and compares it field by field.
// Depends on af3d_pkg.
module affine3d_inlier_scoring_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [af3d_pkg::Q_W-1:0]        cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [af3d_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [af3d_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              pending,
    output int                              results_seen,
    output int                              inliers_seen
);
    import af3d_pkg::*;

    typedef struct packed {
        logic [RES_W-1:0] residual_sq;
        logic             is_inlier;
        logic [CNT_W-1:0] inlier_total;
        logic             set_done;
    } score_t;

    score_t                awaited_scores[$];
    logic signed [Q_W-1:0] coef_q [COEF_COUNT];
    logic [CNT_W-1:0]      inlier_cnt;
    logic [Q_W-1:0]        dist_q;

    // Map the source point, subtract the target, floor each component to Q16.16,
    // then sum the squares with saturation.
    function automatic logic [RES_W-1:0] squared_residual(
        input logic signed [Q_W-1:0] sx, sy, sz, dx, dy, dz);
        logic signed [71:0]    acc;
        logic signed [71:0]    comp;
        logic [71:0]           mag;
        logic [65:0]           total;
        logic signed [Q_W-1:0] tgt [3];
        bit                    clipped;
        int                    r;
        tgt[0]  = dx;
        tgt[1]  = dy;
        tgt[2]  = dz;
        total   = '0;
        clipped = 1'b0;
        for (r = 0; r < 3; r++) begin
            acc = coef_q[r*4] * sx + coef_q[r*4+1] * sy + coef_q[r*4+2] * sz
                + coef_q[r*4+3] * 72'sd65536 - tgt[r] * 72'sd65536;
            comp = acc >>> FRAC_W;
            mag  = (comp < 0) ? -comp : comp;
            if (mag >= 72'd4294967296)
                clipped = 1'b1;
            else
                total = total + mag[31:0] * mag[31:0];
        end
        if (clipped || total > 66'h0_FFFF_FFFF_FFFF_FFFF)
            return '1;
        else
            return total[RES_W-1:0];
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        score_t           want;
        score_t           got;
        logic [RES_W-1:0] limit_sq;
        if (!aresetn) begin
            awaited_scores.delete();
            foreach (coef_q[i]) coef_q[i] = '0;
            inlier_cnt   = '0;
            dist_q       = DIST_RESET;
            fail_count   = 0;
            pending      = 0;
            results_seen = 0;
            inliers_seen = 0;
        end else begin
            if (cfg_we)
                dist_q = cfg_wdata;
            // Predict on the input item first: it can never be the one leaving now.
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_LOAD) begin
                    if (s_tdata[3:0] < COEF_COUNT)
                        coef_q[s_tdata[3:0]] = s_tdata[35:4];
                end else begin
                    want.residual_sq = squared_residual(s_tdata[67:36], s_tdata[99:68],
                        s_tdata[131:100], s_tdata[163:132], s_tdata[195:164],
                        s_tdata[227:196]);
                    limit_sq = 64'(dist_q) * 64'(dist_q);
                    want.is_inlier = (want.residual_sq <= limit_sq);
                    if (want.is_inlier && inlier_cnt < COUNT_CAP)
                        inlier_cnt = inlier_cnt + 1'b1;
                    want.inlier_total = inlier_cnt;
                    want.set_done     = s_tlast;
                    if (s_tlast)
                        inlier_cnt = '0;
                    awaited_scores.push_back(want);
                end
            end
            if (m_tvalid && m_tready) begin
                got.residual_sq  = m_tdata[63:0];
                got.inlier_total = m_tdata[80:64];
                got.is_inlier    = m_tuser;
                got.set_done     = m_tlast;
                results_seen++;
                if (got.is_inlier === 1'b1)
                    inliers_seen++;
                if (awaited_scores.size() == 0) begin
                    fail_count++;
                    $error("result with nothing awaited: residual_sq 0x%0h",
                           got.residual_sq);
                end else begin
                    want = awaited_scores.pop_front();
                    check_field("residual_sq", want.residual_sq, got.residual_sq);
                    check_field("is_inlier", 64'(want.is_inlier), 64'(got.is_inlier));
                    check_field("inlier_total", 64'(want.inlier_total),
                                64'(got.inlier_total));
                    check_field("set_done", 64'(want.set_done), 64'(got.set_done));
                end
            end
            pending = awaited_scores.size();
        end
    end

endmodule

// File: tb/sv/affine3d_inlier_scoring_tb.sv
// Top of the affine 3-D inlier scoring testbench: clock, reset, stimulus, stream idling
// and the verdict. Depends on af3d_pkg, affine3d_inlier_scoring and its checker.
module affine3d_inlier_scoring_tb;
    import af3d_pkg::*;

    localparam int CYCLE_LIMIT    = 4_000_000;
    localparam int SETTLE_CYCLES  = 24;     // wait after the last result, longer than a point occupies the block
    localparam int PHASE_ITEMS    = 128;
    localparam int PHASE_COUNT    = 8;

    localparam logic [Q_W-1:0] ONE   = 32'h0001_0000;
    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [Q_W-1:0]        cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    int          fail_count;
    int          pending;
    int          results_seen;
    int          inliers_seen;

    // Stimulus-side copy of the model, used only to aim targets near the mapped source
    int          model_q [COEF_COUNT];
    int unsigned dist_now;
    bit          tx_gaps_on   = 1'b1;
    bit          rx_stalls_on = 1'b1;
    int          items_sent   = 0;
    int          dist_writes  = 0;
    int          cycle_count  = 0;
    int          stall_left   = 0;

    affine3d_inlier_scoring i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    affine3d_inlier_scoring_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .inliers_seen (inliers_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("affine3d_inlier_scoring_tb: errors");
            $finish;
        end
    end

    // Result side: hold ready low for stalls of random length, mostly short, a few long.
    // Drive on the falling edge so the block sees a settled value at the rising edge.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (rx_stalls_on && $urandom_range(0, 99) < 20)
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                          : $urandom_range(10, 50);
        end
    end

    // Gap before an input item: none about half the time, mostly short, a few long
    function automatic int gap_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (!tx_gaps_on || pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Present one item at the falling edge and hold it until the block takes it
    task automatic push_item(input logic op, input logic [3:0] idx,
                             input logic [Q_W-1:0] val, sx, sy, sz, dx, dy, dz,
                             input logic last);
        int gap;
        gap = gap_cycles();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {4'b0, dz, dy, dx, sz, sy, sx, val, idx};
        s_tuser  <= op;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Load one coefficient; fill the point fields and tlast with junk the block must ignore
    task automatic send_load(input logic [3:0] idx, input logic [Q_W-1:0] val);
        if (idx < COEF_COUNT)
            model_q[idx] = val;
        push_item(OP_LOAD, idx, val, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, 1'($urandom_range(0, 1)));
    endtask

    // Score one point pair; the coefficient fields carry junk
    task automatic send_point(input logic [Q_W-1:0] sx, sy, sz, dx, dy, dz,
                              input logic last);
        push_item(OP_SCORE, 4'($urandom_range(0, 15)), $urandom, sx, sy, sz, dx, dy, dz,
                  last);
    endtask

    // Drop valid, wait for every awaited result, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_distance(input logic [Q_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        dist_now = value;
        dist_writes++;
    endtask

    // Coefficient within +-4.0, or anything at all
    function automatic logic [Q_W-1:0] rand_coef(input bit wide);
        if (wide)
            return $urandom;
        else
            return 32'($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
    endfunction

    // Uniform offset in [-amp, amp], amp clipped to 31 bits
    function automatic longint jitter(input longint amp);
        longint span;
        if (amp <= 0)
            return 0;
        span = (amp > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : amp;
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    task automatic load_model(input bit wide, input bit reverse);
        int i;
        for (i = 0; i < COEF_COUNT; i++)
            send_load(4'(reverse ? COEF_COUNT - 1 - i : i), rand_coef(wide));
    endtask

    // Point whose target is the mapped source plus a per-axis offset within amp, so
    // that the residual lands near the limit from either side
    task automatic send_fitted_point(input longint amp, input logic last);
        logic [Q_W-1:0] src [3];
        logic [Q_W-1:0] dst [3];
        longint         acc;
        bit             far;
        int             r;
        far = ($urandom_range(0, 15) == 0);
        for (r = 0; r < 3; r++)
            src[r] = far ? $urandom : 32'($urandom_range(0, 32'h0100_0000) - 32'h0080_0000);
        for (r = 0; r < 3; r++) begin
            acc = longint'(model_q[r*4]) * longint'($signed(src[0]))
                + longint'(model_q[r*4+1]) * longint'($signed(src[1]))
                + longint'(model_q[r*4+2]) * longint'($signed(src[2]));
            acc = (acc >>> FRAC_W) + longint'(model_q[r*4+3]) + jitter(amp);
            dst[r] = acc[31:0];
        end
        send_point(src[0], src[1], src[2], dst[0], dst[1], dst[2], last);
    endtask

    initial begin : stimulus
        int          i;
        int          k;
        int          p;
        int          pick;
        longint      amp;
        logic [3:0]  idx;
        int unsigned dist_plan [PHASE_COUNT];

        dist_plan[0] = 32'h0000_0000;
        dist_plan[1] = 32'hFFFF_FFFF;
        dist_plan[2] = 32'h0001_0000;
        dist_plan[3] = $urandom_range(0, 32'h0008_0000);
        dist_plan[4] = 32'h0000_0001;
        dist_plan[5] = $urandom;
        dist_plan[6] = $urandom_range(0, 32'h0000_4000);
        dist_plan[7] = DIST_RESET;
        dist_now     = DIST_RESET;

        // Hold reset low, then release it on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset distance of 3.0: identity model, no translation
        for (i = 0; i < COEF_COUNT; i++)
            send_load(4'(i), (i == 0 || i == 5 || i == 10) ? ONE : 32'h0);
        // exact fit
        send_point(ONE, 32'(2 * ONE), 32'(3 * ONE), ONE, 32'(2 * ONE), 32'(3 * ONE), 1'b0);
        // residual exactly on the limit, then one step past it
        send_point(32'h0, 32'h0, 32'h0, 32'hFFFD_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 32'hFFFC_FFFF, 32'h0, 32'h0, 1'b0);
        // largest component that still squares without clipping; closes the first set
        send_point(Q_MAX, 32'h0, 32'h0, Q_MIN, 32'h0, 32'h0, 1'b1);
        // sums of squares that overflow, positive and negative components
        send_point(Q_MAX, Q_MAX, 32'h0, Q_MIN, Q_MIN, 32'h0, 1'b0);
        send_point(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0);
        // one LSB of translation pushes the component to 2^32
        send_load(4'd3, 32'h0000_0001);
        send_point(Q_MAX, 32'h0, 32'h0, Q_MIN, 32'h0, 32'h0, 1'b1);
        // half-scale coefficient: the floor rounds -0.5 LSB down to -1 and +0.5 to 0
        send_load(4'd3, 32'h0);
        send_load(4'd0, 32'h0000_8000);
        send_point(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_point(32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        // indexes past eleven must leave the model alone
        send_load(4'd0, ONE);
        send_load(4'd12, Q_MIN);
        send_load(4'd15, Q_MAX);
        send_point(ONE, ONE, ONE, ONE, ONE, ONE, 1'b1);
        drain();

        // Random phases: one distance setting and a fresh model each
        for (p = 0; p < PHASE_COUNT; p++) begin
            tx_gaps_on   = (p != 2);
            rx_stalls_on = (p != 2);
            write_distance(dist_plan[p]);
            load_model(p == 4 || p == 6, p[0]);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    // mid-set reload, sometimes to an ignored index
                    idx = 4'($urandom_range(0, 15));
                    send_load(idx, rand_coef($urandom_range(0, 3) == 0));
                end else if (pick < 18) begin
                    send_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               1'($urandom_range(0, 11) == 0));
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        amp = 0;
                    else if (pick < 8)
                        amp = longint'(dist_now) / 2;
                    else
                        amp = longint'(dist_now) * 2;
                    send_fitted_point(amp, 1'($urandom_range(0, 11) == 0));
                end
            end
            drain();
        end

        $display("summary: %0d items sent, %0d results checked, %0d of them inliers",
                 items_sent, results_seen, inliers_seen);
        $display("summary: %0d distance settings, model reloads, ignored loads, %s",
                 dist_writes, "clipped and overflowing residuals");
        if (fail_count == 0 && pending == 0)
            $display("affine3d_inlier_scoring_tb: clean");
        else
            $display("affine3d_inlier_scoring_tb: errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/af3d_pkg.sv
design/affine3d_inlier_scoring.sv
tb/sv/affine3d_inlier_scoring_checker.sv
tb/sv/affine3d_inlier_scoring_tb.sv
